// ----- rtl/pfe_pkg.sv -----
package pfe_pkg;

  localparam int VALUE_W   = 64;
  localparam int MAX_OUT   = 23;
  localparam int STEP_BITS = 4;

  localparam logic [3:0] DEC_RADIX  = 4'd10;
  localparam logic [3:0] GROUP_LAST = 4'(VALUE_W / STEP_BITS - 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_XU    = 8'h58;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_O     = 8'h6f;

  typedef struct packed {
    logic               command;
    logic [VALUE_W-1:0] value;
  } pfe_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       status;
    logic       last;
  } pfe_out_t;

  typedef enum logic [2:0] {
    PH_TEXT, PH_PCT, PH_SHORT, PH_LONG, PH_SPEC, PH_WAIT
  } phase_e;

  typedef enum logic [2:0] {
    W_DEF, W_HH, W_H, W_L, W_LL
  } width_e;

  typedef enum logic [2:0] {
    K_NONE, K_SDEC, K_UDEC, K_HEX, K_OCT, K_CHAR
  } kind_e;

  typedef enum logic [2:0] {
    RES_BYTE, RES_PCT, RES_ERR, RES_CHAR, RES_NUM
  } res_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ONE, ST_DIV, ST_SIGN, ST_EMIT
  } state_e;

  typedef struct packed {
    logic   capture;
    res_e   res;
    kind_e  kind;
    width_e wcode;
    logic   put_one;
    logic   div_step;
    logic   sign_step;
    logic   emit;
  } pfe_cmd_t;

  typedef struct packed {
    logic out_free;
    logic dig_fin;
    logic emit_last;
  } pfe_sts_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else begin
      c = 8'h57 + {4'd0, d};
    end
    return c;
  endfunction

endpackage

// ----- rtl/pfe_ctrl.sv -----
module pfe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pfe_pkg::pfe_in_t  in_i,
  input  pfe_pkg::pfe_sts_t sts_i,
  output pfe_pkg::pfe_cmd_t cmd_o
);
  import pfe_pkg::*;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  width_e width_q, width_d;
  kind_e  kind_q,  kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_TEXT;
      width_q <= W_DEF;
      kind_q  <= K_NONE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      width_q <= width_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic       spec;
    logic       to_text;
    b         = in_i.value[7:0];
    spec      = 1'b0;
    to_text   = 1'b0;
    state_d   = state_q;
    phase_d   = phase_q;
    width_d   = width_q;
    kind_d    = kind_q;
    in_stall_o = 1'b1;
    cmd_o           = '0;
    cmd_o.res       = RES_ERR;
    cmd_o.kind      = kind_q;
    cmd_o.wcode     = width_q;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (phase_q == PH_WAIT) begin
            if (in_i.command) begin
              to_text = 1'b1;
              if (kind_q == K_CHAR) begin
                cmd_o.res = RES_CHAR;
                state_d   = ST_ONE;
              end else begin
                cmd_o.res = RES_NUM;
                state_d   = ST_DIV;
              end
            end else begin
              state_d = ST_ONE;
            end
          end else if (in_i.command) begin
            state_d = ST_ONE;
          end else if (b == CH_NUL) begin
            to_text = 1'b1;
          end else begin
            unique case (phase_q)
              PH_TEXT: begin
                if (b == CH_PCT) begin
                  phase_d = PH_PCT;
                end else begin
                  cmd_o.res = RES_BYTE;
                  state_d   = ST_ONE;
                end
              end
              PH_PCT: begin
                if (b == CH_H) begin
                  width_d = W_H;
                  phase_d = PH_SHORT;
                end else if (b == CH_L) begin
                  width_d = W_L;
                  phase_d = PH_LONG;
                end else begin
                  spec = 1'b1;
                end
              end
              PH_SHORT: begin
                if (b == CH_H) begin
                  width_d = W_HH;
                  phase_d = PH_SPEC;
                end else begin
                  spec = 1'b1;
                end
              end
              PH_LONG: begin
                if (b == CH_L) begin
                  width_d = W_LL;
                  phase_d = PH_SPEC;
                end else begin
                  spec = 1'b1;
                end
              end
              default: spec = 1'b1;
            endcase
            if (spec) begin
              phase_d = PH_WAIT;
              unique case (b) inside
                CH_C:             kind_d = K_CHAR;
                CH_D, CH_I:       kind_d = K_SDEC;
                CH_U:             kind_d = K_UDEC;
                CH_X, CH_XU, CH_P: kind_d = K_HEX;
                CH_O:             kind_d = K_OCT;
                CH_PCT: begin
                  to_text   = 1'b1;
                  cmd_o.res = RES_PCT;
                  state_d   = ST_ONE;
                end
                default: to_text = 1'b1;
              endcase
            end
          end
          if (to_text) begin
            phase_d = PH_TEXT;
            width_d = W_DEF;
            kind_d  = K_NONE;
          end
        end
      end
      ST_ONE: begin
        if (sts_i.out_free) begin
          cmd_o.put_one = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.dig_fin) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        cmd_o.sign_step = 1'b1;
        state_d         = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/pfe_dp.sv -----
module pfe_dp #(
  parameter int INT_BITS    = 16,
  parameter int DIGIT_DEPTH = 23
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfe_pkg::pfe_in_t  in_i,
  input  pfe_pkg::pfe_cmd_t cmd_i,
  output pfe_pkg::pfe_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pfe_pkg::pfe_out_t out_o
);
  import pfe_pkg::*;

  localparam int CAP = (DIGIT_DEPTH < MAX_OUT) ? DIGIT_DEPTH : MAX_OUT;
  localparam int NW  = $clog2(CAP + 1);
  localparam int AW  = $clog2(DIGIT_DEPTH);
  localparam logic [6:0] INT_W  = 7'(INT_BITS);
  localparam logic [6:0] FULL_W = 7'(VALUE_W);
  localparam logic [NW-1:0] CAP_N = NW'(CAP);

  logic [7:0]         store_q [DIGIT_DEPTH];
  logic [7:0]         char_q, char_d;
  logic               err_q, err_d;
  logic               neg_q, neg_d;
  kind_e              kind_q, kind_d;
  logic [VALUE_W-1:0] work_q, work_d;
  logic [3:0]         rem_q, rem_d;
  logic [3:0]         grp_q, grp_d;
  logic [NW-1:0]      n_q, n_d;
  logic [AW-1:0]      rd_q, rd_d;
  logic               out_valid_q, out_valid_d;
  pfe_out_t           out_q, out_d;

  logic [6:0]         wbits;
  logic [VALUE_W-1:0] mask, masked, mag;
  logic               neg_in;
  logic [VALUE_W-1:0] work_div;
  logic [3:0]         digit, r_dec;
  logic [3:0]         qbits;
  logic               ready;
  logic               wr_en;
  logic [7:0]         wr_data;
  logic               out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (cmd_i.wcode) inside
      W_HH, W_H: wbits = 7'd16;
      W_L:       wbits = 7'd32;
      W_LL:      wbits = 7'd64;
      default:   wbits = INT_W;
    endcase
    mask   = {VALUE_W{1'b1}} >> (FULL_W - wbits);
    masked = in_i.value & mask;
    neg_in = (cmd_i.kind == K_SDEC) && masked[6'(wbits - 7'd1)];
    mag    = neg_in ? ((~masked + 64'd1) & mask) : masked;
  end

  always_comb begin
    logic [4:0] t;
    logic [3:0] r;
    r     = rem_q;
    qbits = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, work_q[VALUE_W-1-i]};
      if (t >= {1'b0, DEC_RADIX}) begin
        r                       = 4'(t - {1'b0, DEC_RADIX});
        qbits[STEP_BITS-1-i]    = 1'b1;
      end else begin
        r = t[3:0];
      end
    end
    r_dec = r;
    case (kind_q)
      K_HEX: begin
        work_div = work_q >> 4;
        digit    = work_q[3:0];
        ready    = 1'b1;
      end
      K_OCT: begin
        work_div = work_q >> 3;
        digit    = {1'b0, work_q[2:0]};
        ready    = 1'b1;
      end
      default: begin
        work_div = {work_q[VALUE_W-STEP_BITS-1:0], qbits};
        digit    = r_dec;
        ready    = (grp_q == GROUP_LAST);
      end
    endcase
  end

  assign sts_o.out_free  = out_free;
  assign sts_o.dig_fin   = ready && (work_div == '0);
  assign sts_o.emit_last = (rd_q == '0);

  always_comb begin
    char_d      = char_q;
    err_d       = err_q;
    neg_d       = neg_q;
    kind_d      = kind_q;
    work_d      = work_q;
    rem_d       = rem_q;
    grp_d       = grp_q;
    n_d         = n_q;
    rd_d        = rd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    wr_data     = hex_char(digit);

    if (cmd_i.capture) begin
      case (cmd_i.res)
        RES_BYTE, RES_CHAR: char_d = in_i.value[7:0];
        RES_PCT:            char_d = CH_PCT;
        default:            char_d = CH_NUL;
      endcase
      err_d  = (cmd_i.res == RES_ERR);
      neg_d  = neg_in;
      kind_d = cmd_i.kind;
      work_d = mag;
      rem_d  = '0;
      grp_d  = '0;
      n_d    = '0;
    end

    if (cmd_i.div_step) begin
      work_d = work_div;
      if (ready) begin
        rem_d = '0;
        grp_d = '0;
        if (n_q < CAP_N) begin
          wr_en = 1'b1;
          n_d   = n_q + 1'b1;
        end
      end else begin
        rem_d = r_dec;
        grp_d = grp_q + 4'd1;
      end
    end

    if (cmd_i.sign_step) begin
      wr_data = CH_MINUS;
      if (neg_q && (n_q < CAP_N)) begin
        wr_en = 1'b1;
        n_d   = n_q + 1'b1;
      end
      rd_d = AW'(n_d - 1'b1);
    end

    if (cmd_i.put_one) begin
      out_d       = '{character: char_q, status: err_q, last: 1'b1};
      out_valid_d = 1'b1;
    end

    if (cmd_i.emit) begin
      out_d       = '{character: store_q[rd_q], status: 1'b0, last: (rd_q == '0)};
      out_valid_d = 1'b1;
      rd_d        = rd_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      work_q      <= '0;
      rem_q       <= '0;
      grp_q       <= '0;
      n_q         <= '0;
      rd_q        <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      work_q      <= work_d;
      rem_q       <= rem_d;
      grp_q       <= grp_d;
      n_q         <= n_d;
      rd_q        <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    err_q  <= err_d;
    neg_q  <= neg_d;
    kind_q <= kind_d;
    out_q  <= out_d;
    if (wr_en) begin
      store_q[n_q[AW-1:0]] <= wr_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/printf_format_engine_top.sv -----
// Echo bytes, %%, c arguments and errors: one character, through ST_ONE to the output register.
// Numeric arguments: hex and octal give a digit per step, decimal a digit per 64-bit pass of a
// 4-bit-per-cycle restoring divide by ten; a sign step follows, then 1 digit/cycle unless stalled.
// Items causing no result leave the engine idle; input stalls until the current item is finished.
// Reset is asynchronous and active low; parser returns to plain text, no clearing pass.
module printf_format_engine_top #(
  parameter int INT_BITS    = 16,
  parameter int DIGIT_DEPTH = 23
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pfe_pkg::pfe_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pfe_pkg::pfe_out_t out_o
);
  import pfe_pkg::*;

  pfe_cmd_t cmd;
  pfe_sts_t sts;

  pfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfe_dp #(
    .INT_BITS    (INT_BITS),
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

// ----- rtl/pfe_checker.sv -----
module pfe_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pfe_pkg::pfe_out_t out_o
);
  import pfe_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  // error transaction is a single zero character
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status |-> out_o.last && (out_o.character == 8'h00))
    else $error("malformed error result");

  // digits of one number come without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_o.last |=> out_valid_o)
    else $error("gap inside a multi-character result");

  // no new item while a number is still being emitted
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.last |-> in_stall_o)
    else $error("input accepted during digit output");

endmodule

bind printf_format_engine_top pfe_checker u_pfe_checker (.*);
